FILE: rtl/core/mdk_pkg.sv
// Package for the Morse digit keyer: item and result types, operation codes,
// register indexes, reset values and the digit-to-dash-pattern table.
// No dependencies.
package mdk_pkg;

  localparam int unsigned ELEMENTS_PER_DIGIT = 5;
  localparam int unsigned TICK_W             = 16;
  localparam int unsigned IDX_W              = 3;
  localparam int unsigned CFG_IDX_W          = 2;

  localparam logic [IDX_W-1:0] LAST_ELEMENT  = IDX_W'(ELEMENTS_PER_DIGIT - 1);
  localparam logic [3:0]       MAX_DIGIT     = 4'd9;

  localparam logic [TICK_W-1:0] DOT_TICKS_RST      = 16'd100;
  localparam logic [TICK_W-1:0] DASH_TICKS_RST     = 16'd250;
  localparam logic [TICK_W-1:0] CHAR_GAP_TICKS_RST = 16'd500;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } mdk_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT_TICKS      = 2'd0,
    REG_DASH_TICKS     = 2'd1,
    REG_CHAR_GAP_TICKS = 2'd2
  } mdk_reg_t;

  typedef struct packed {
    mdk_op_t    operation;
    logic [3:0] digit;
  } mdk_item_t;

  typedef struct packed {
    logic lamp;
    logic busy_res;
    logic rejected;
    logic finished;
  } mdk_result_t;

  // Bit i set when element i (first sent is bit 0) is a dash.
  function automatic logic [ELEMENTS_PER_DIGIT-1:0] dash_table(input logic [3:0] digit);
    logic [ELEMENTS_PER_DIGIT-1:0] pat;
    unique case (digit)
      4'd0:    pat = 5'b11111;
      4'd1:    pat = 5'b11110;
      4'd2:    pat = 5'b11100;
      4'd3:    pat = 5'b11000;
      4'd4:    pat = 5'b10000;
      4'd5:    pat = 5'b00000;
      4'd6:    pat = 5'b00001;
      4'd7:    pat = 5'b00011;
      4'd8:    pat = 5'b00111;
      4'd9:    pat = 5'b01111;
      default: pat = 5'b00000;
    endcase
    return pat;
  endfunction

endpackage

FILE: rtl/core/morse_digit_keyer.sv
// Morse digit keyer top level: keying state, timing registers and a
// two-entry result buffer. Depends on mdk_pkg.
//
// Usage:
//   Input channel (item_valid / item_stall / item) carries transactions of
//   two kinds: a load (operation OP_LOAD) starts keying a digit 0 to 9, a
//   tick (OP_TICK) advances time by one step. Every accepted transaction
//   produces exactly one result transaction (result_valid / result_stall /
//   result) holding the lamp level, busy flag, reject flag and the finished
//   pulse that marks the end of the final character gap.
//   A load while busy or of a code above 9 is rejected; state is untouched.
//   Timing registers (dot, dash, character gap, in ticks) are written via
//   cfg_write / cfg_index / cfg_data; the user must do so only while idle,
//   which the block itself does not enforce. Unknown indexes are ignored.
// Throughput:
//   One transaction per clock while item_stall is low; keying state and the
//   result are registered when it is accepted. The state update is a single
//   decrement/compare and reload of the 16-bit phase counter.
// Stall behavior:
//   The result register is backed by one skid entry. While the receiver
//   stalls, one further transaction is still accepted into the skid entry;
//   item_stall rises only when that entry is occupied.
// Reset:
//   rst (synchronous) returns to idle with the lamp off, empties the result
//   buffer and restores timing registers to 100 / 250 / 500 ticks.
module morse_digit_keyer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  mdk_pkg::mdk_item_t               item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output mdk_pkg::mdk_result_t             result,
  input  logic                             cfg_write,
  input  logic [mdk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mdk_pkg::TICK_W-1:0]       cfg_data
);
  import mdk_pkg::*;

  // Timing registers
  logic [TICK_W-1:0] dot_ticks;
  logic [TICK_W-1:0] dash_ticks;
  logic [TICK_W-1:0] char_gap_ticks;

  // Keying state
  logic [ELEMENTS_PER_DIGIT-1:0] dash_pattern, dash_pattern_next;
  logic [IDX_W-1:0]              element_index, element_index_next;
  logic                          lamp_phase, lamp_phase_next;
  logic [TICK_W-1:0]             ticks_left, ticks_left_next;
  logic                          keying_active, keying_active_next;

  // Result buffer: head register plus skid entry
  mdk_result_t res_next;
  mdk_result_t skid;
  logic        skid_valid;

  logic accept;
  logic pop;
  logic [IDX_W-1:0] idx_inc;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;
  assign idx_inc    = element_index + IDX_W'(1);

  // Timing register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks      <= DOT_TICKS_RST;
      dash_ticks     <= DASH_TICKS_RST;
      char_gap_ticks <= CHAR_GAP_TICKS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DOT_TICKS:      dot_ticks      <= cfg_data;
        REG_DASH_TICKS:     dash_ticks     <= cfg_data;
        REG_CHAR_GAP_TICKS: char_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next keying state for the transaction at the input
  always_comb begin
    dash_pattern_next  = dash_pattern;
    element_index_next = element_index;
    lamp_phase_next    = lamp_phase;
    ticks_left_next    = ticks_left;
    keying_active_next = keying_active;
    res_next           = '0;

    if (item.operation == OP_LOAD) begin
      if (keying_active || item.digit > MAX_DIGIT) begin
        res_next.rejected = 1'b1;
      end else begin
        dash_pattern_next  = dash_table(item.digit);
        element_index_next = '0;
        lamp_phase_next    = 1'b1;
        keying_active_next = 1'b1;
        ticks_left_next    = dash_pattern_next[0] ? dash_ticks : dot_ticks;
      end
    end else if (keying_active) begin
      if (ticks_left > TICK_W'(1)) begin
        ticks_left_next = ticks_left - TICK_W'(1);
      end else if (lamp_phase) begin
        // element done: inter-element gap, or character gap after the last
        lamp_phase_next = 1'b0;
        ticks_left_next = (element_index == LAST_ELEMENT) ? char_gap_ticks : dot_ticks;
      end else if (element_index == LAST_ELEMENT) begin
        keying_active_next = 1'b0;
        ticks_left_next    = '0;
        element_index_next = '0;
        res_next.finished  = 1'b1;
      end else begin
        element_index_next = idx_inc;
        lamp_phase_next    = 1'b1;
        ticks_left_next    = dash_pattern[idx_inc] ? dash_ticks : dot_ticks;
      end
    end

    res_next.lamp     = lamp_phase_next & keying_active_next;
    res_next.busy_res = keying_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_pattern  <= '0;
      element_index <= '0;
      lamp_phase    <= 1'b0;
      ticks_left    <= '0;
      keying_active <= 1'b0;
    end else if (accept) begin
      dash_pattern  <= dash_pattern_next;
      element_index <= element_index_next;
      lamp_phase    <= lamp_phase_next;
      ticks_left    <= ticks_left_next;
      keying_active <= keying_active_next;
    end
  end

  // Result buffer control. New results go to the head when it is empty or
  // draining this cycle, otherwise into the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (accept) begin
        if (!result_valid || pop) begin
          result_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        result_valid <= skid_valid;
        skid_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!result_valid || pop) begin
        result <= res_next;
      end else begin
        skid <= res_next;
      end
    end else if (pop && skid_valid) begin
      result <= skid;
    end
  end

endmodule

FILE: rtl/core/mdk_checker.sv
// Port-level checker for the Morse digit keyer, bound to the top level.
// Depends on mdk_pkg and morse_digit_keyer.
module mdk_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  result_valid,
  input logic                  result_stall,
  input mdk_pkg::mdk_result_t  result
);
  import mdk_pkg::*;

  // A stalled result transaction holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Buffer empties on reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // Lamp is lit only while keying.
  a_lamp_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.lamp |-> result.busy_res)
    else $error("lamp on while idle");

  // End of keying leaves the block idle and dark.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.finished |-> !result.busy_res && !result.lamp)
    else $error("finished while still busy");

  // A refused load is never the final tick.
  a_reject_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.rejected |-> !result.finished)
    else $error("rejected and finished together");

endmodule

bind morse_digit_keyer mdk_checker u_mdk_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
